[design/tgad_pkg.sv]
// Shared types and constants of the TGA stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package tgad_pkg;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PACKET,
      PH_PIXEL
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_HEADER_OK = 3'd0,
      STATUS_PIXEL     = 3'd1,
      STATUS_BAD_TYPE  = 3'd2,
      STATUS_BAD_SIZE  = 3'd3,
      STATUS_OVERFLOW  = 3'd4,
      STATUS_TRUNCATED = 3'd5
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        has_alpha;
      logic [7:0]  run_length;
      logic        image_done;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } rsp_item_type;

   // up to two results per input beat, item0 always filled first
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   // header byte positions
   localparam logic [4:0] HDR_TYPE_POS  = 5'd2;
   localparam logic [4:0] HDR_ID_LEN    = 5'd12;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_BPP_POS   = 5'd16;

   localparam logic [7:0] TYPE_RAW        = 8'd2;
   localparam logic [7:0] TYPE_RLE        = 8'd10;
   localparam logic [7:0] BPP_24          = 8'd24;
   localparam logic [7:0] BPP_32          = 8'd32;
   localparam logic [7:0] RLE_REPEAT_FLAG = 8'd128;
   localparam logic [7:0] RLE_REPEAT_BIAS = 8'd127;

   // result queue
   localparam int          RSP_DEPTH    = 4;
   localparam int          RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int          RSP_CNT_W    = $clog2(RSP_DEPTH + 1);
   localparam logic [RSP_CNT_W-1:0] RSP_ROOM_LIMIT = RSP_CNT_W'(RSP_DEPTH - 2);

endpackage
`default_nettype wire

[design/tgad_if.sv]
// Stream channel interfaces: file bytes in, decoded results out.
`timescale 1ns / 1ps
`default_nettype none
interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;
   logic       end_of_file;

   modport source (output valid, output data_byte, output start_of_file,
                   output end_of_file, input ready);
   modport sink (input valid, input data_byte, input start_of_file,
                 input end_of_file, output ready);
   modport monitor (input valid, input ready, input data_byte, input start_of_file,
                    input end_of_file);
endinterface

interface tgad_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic        has_alpha;
   logic [7:0]  run_length;
   logic        image_done;
   logic [15:0] image_width;
   logic [15:0] image_height;

   modport source (output valid, output status, output red, output green,
                   output blue, output alpha, output has_alpha, output run_length,
                   output image_done, output image_width, output image_height,
                   input ready);
   modport sink (input valid, input status, input red, input green, input blue,
                 input alpha, input has_alpha, input run_length, input image_done,
                 input image_width, input image_height, output ready);
   modport monitor (input valid, input ready, input status, input red, input green,
                    input blue, input alpha, input has_alpha, input run_length,
                    input image_done, input image_width, input image_height);
endinterface
`default_nettype wire

[design/tga_stream_decoder.sv]
// TGA stream decoder top level: byte parser feeding a result queue.
//
//   channel   dir  beat                                     accept
//   req_chan  in   data_byte, start_of_file, end_of_file    valid && ready
//   rsp_chan  out  status, colour, run_length, done, size   valid && ready
//
// One byte is taken every cycle while req_chan.ready is high; its results are
// written to the queue at the same clock edge and show on rsp_chan once the
// entries ahead of them have drained. A byte gives at most two results; the queue
// drains one per cycle while rsp_chan.ready is high, so req_chan.ready drops only
// while fewer than two of its four entries are free. Reset clears parser and queue
// control; the queue entries and the three held colour bytes carry no reset.
`timescale 1ns / 1ps
`default_nettype none
module tga_stream_decoder
   import tgad_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   tgad_req_if.sink   req_chan,
   tgad_rsp_if.source rsp_chan
);

   push_type     push;
   logic         room;
   logic         beat_valid;
   rsp_item_type head;

   assign req_chan.ready = room;
   assign beat_valid     = req_chan.valid && room;

   tgad_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .beat_valid    (beat_valid),
      .data_byte     (req_chan.data_byte),
      .start_of_file (req_chan.start_of_file),
      .end_of_file   (req_chan.end_of_file),
      .push          (push)
   );

   tgad_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (head)
   );

   assign rsp_chan.status       = head.status;
   assign rsp_chan.red          = head.red;
   assign rsp_chan.green        = head.green;
   assign rsp_chan.blue         = head.blue;
   assign rsp_chan.alpha        = head.alpha;
   assign rsp_chan.has_alpha    = head.has_alpha;
   assign rsp_chan.run_length   = head.run_length;
   assign rsp_chan.image_done   = head.image_done;
   assign rsp_chan.image_width  = head.image_width;
   assign rsp_chan.image_height = head.image_height;

endmodule
`default_nettype wire

[design/tgad_parser.sv]
// Byte parser: header check, packet decode and pixel assembly, one byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module tgad_parser
   import tgad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       beat_valid,
   input  wire logic [7:0] data_byte,
   input  wire logic       start_of_file,
   input  wire logic       end_of_file,
   output push_type        push
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  hpos_ff, hpos_in;
   logic        rle_ff, rle_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_ff, four_in;
   logic [31:0] remain_ff, remain_in;
   logic        repeat_ff, repeat_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  bip_ff, bip_in;
   logic [7:0]  held_ff [3];
   logic        held_we;
   logic [1:0]  held_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hpos_ff   <= '0;
         rle_ff    <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         four_ff   <= 1'b0;
         remain_ff <= '0;
         repeat_ff <= 1'b0;
         left_ff   <= '0;
         bip_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         hpos_ff   <= hpos_in;
         rle_ff    <= rle_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         four_ff   <= four_in;
         remain_ff <= remain_in;
         repeat_ff <= repeat_in;
         left_ff   <= left_in;
         bip_ff    <= bip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[held_idx] <= data_byte;
      end
   end

   always_comb begin
      logic       bad;
      logic [7:0] run;
      logic [7:0] left_after;
      logic       overflow;
      logic       done;
      logic [1:0] last_byte;

      bad        = 1'b0;
      run        = '0;
      left_after = '0;
      overflow   = 1'b0;
      done       = 1'b0;
      last_byte  = '0;

      phase_in  = phase_ff;
      hpos_in   = hpos_ff;
      rle_in    = rle_ff;
      width_in  = width_ff;
      height_in = height_ff;
      four_in   = four_ff;
      remain_in = remain_ff;
      repeat_in = repeat_ff;
      left_in   = left_ff;
      bip_in    = bip_ff;
      held_we   = 1'b0;
      held_idx  = bip_ff;
      push      = '0;

      if (beat_valid) begin
         // restart drops whatever file was in progress
         if (start_of_file) begin
            phase_in  = PH_HEADER;
            hpos_in   = '0;
            rle_in    = 1'b0;
            width_in  = '0;
            height_in = '0;
            four_in   = 1'b0;
            remain_in = '0;
            repeat_in = 1'b0;
            left_in   = '0;
            bip_in    = '0;
         end

         case (phase_in)
            PH_HEADER: begin
               if (hpos_in < HDR_ID_LEN) begin
                  if (hpos_in == HDR_TYPE_POS) begin
                     bad    = !(data_byte == TYPE_RAW || data_byte == TYPE_RLE);
                     rle_in = (data_byte == TYPE_RLE);
                  end else begin
                     bad = (data_byte != 8'd0);
                  end
                  if (bad) begin
                     push.push0        = 1'b1;
                     push.item0.status = STATUS_BAD_TYPE;
                     phase_in          = PH_IDLE;
                  end
               end else if (hpos_in == HDR_WIDTH_LO) begin
                  width_in = {width_in[15:8], data_byte};
               end else if (hpos_in == HDR_WIDTH_HI) begin
                  width_in = {data_byte, width_in[7:0]};
               end else if (hpos_in == HDR_HEIGHT_LO) begin
                  height_in = {height_in[15:8], data_byte};
               end else if (hpos_in == HDR_HEIGHT_HI) begin
                  height_in = {data_byte, height_in[7:0]};
               end else if (hpos_in == HDR_BPP_POS) begin
                  if (width_in == 16'd0 || height_in == 16'd0 ||
                      (data_byte != BPP_24 && data_byte != BPP_32)) begin
                     push.push0        = 1'b1;
                     push.item0.status = STATUS_BAD_SIZE;
                     phase_in          = PH_IDLE;
                  end else begin
                     four_in = (data_byte == BPP_32);
                  end
               end else begin
                  // descriptor byte: header complete
                  remain_in               = {16'd0, width_in} * {16'd0, height_in};
                  push.push0              = 1'b1;
                  push.item0.status       = STATUS_HEADER_OK;
                  push.item0.has_alpha    = four_in;
                  push.item0.image_width  = width_in;
                  push.item0.image_height = height_in;
                  bip_in    = '0;
                  repeat_in = 1'b0;
                  left_in   = '0;
                  phase_in  = rle_in ? PH_PACKET : PH_PIXEL;
               end
               if (phase_in == PH_HEADER) begin
                  hpos_in = hpos_in + 5'd1;
               end
            end
            PH_PACKET: begin
               if (data_byte < RLE_REPEAT_FLAG) begin
                  repeat_in = 1'b0;
                  left_in   = data_byte + 8'd1;
               end else begin
                  repeat_in = 1'b1;
                  left_in   = data_byte - RLE_REPEAT_BIAS;
               end
               bip_in   = '0;
               phase_in = PH_PIXEL;
            end
            PH_PIXEL: begin
               last_byte = four_in ? 2'd3 : 2'd2;
               if (bip_in < last_byte) begin
                  held_we  = 1'b1;
                  held_idx = bip_in;
                  bip_in   = bip_in + 2'd1;
               end else begin
                  bip_in = '0;
                  if (!rle_in) begin
                     run        = 8'd1;
                     left_after = '0;
                  end else if (repeat_in) begin
                     // clip the run to what the image still needs
                     if ({24'd0, left_in} < remain_in) begin
                        run = left_in;
                     end else begin
                        run = remain_in[7:0];
                     end
                     left_after = '0;
                  end else begin
                     run        = 8'd1;
                     left_after = left_in - 8'd1;
                  end
                  overflow  = rle_in && repeat_in && (left_in > run);
                  remain_in = remain_in - {24'd0, run};
                  left_in   = left_after;
                  done      = (remain_in == 32'd0);

                  push.push0             = 1'b1;
                  push.item0.status      = STATUS_PIXEL;
                  push.item0.blue        = held_ff[0];
                  push.item0.green       = held_ff[1];
                  push.item0.red         = four_in ? held_ff[2] : data_byte;
                  push.item0.alpha       = four_in ? data_byte : 8'd0;
                  push.item0.has_alpha   = four_in;
                  push.item0.run_length  = run;
                  push.item0.image_done  = done;

                  if (done) begin
                     if (rle_in && left_in != 8'd0) begin
                        overflow = 1'b1;
                     end
                     if (overflow) begin
                        push.push1        = 1'b1;
                        push.item1.status = STATUS_OVERFLOW;
                     end
                     phase_in = PH_IDLE;
                  end else if (rle_in && left_in == 8'd0) begin
                     phase_in = PH_PACKET;
                  end
               end
            end
            default: begin
               // idle: bytes without a file start are dropped
            end
         endcase

         if (end_of_file && phase_in != PH_IDLE) begin
            if (push.push0) begin
               push.push1        = 1'b1;
               push.item1.status = STATUS_TRUNCATED;
            end else begin
               push.push0        = 1'b1;
               push.item0.status = STATUS_TRUNCATED;
            end
            phase_in = PH_IDLE;
         end
      end
   end

endmodule
`default_nettype wire

[design/tgad_rsp_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
`default_nettype none
module tgad_rsp_fifo
   import tgad_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire push_type push,
   output logic        room,
   output logic        out_valid,
   input  wire logic   out_ready,
   output rsp_item_type out_item
);

   rsp_item_type               entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]       count_ff, count_in;
   logic [RSP_PTR_W-1:0]       wr_ptr_second;
   logic                       pop;

   assign pop           = out_valid && out_ready;
   assign out_valid     = (count_ff != '0);
   assign out_item      = entry_ff[rd_ptr_ff];
   // second result lands right after the first
   assign wr_ptr_second = wr_ptr_ff + RSP_PTR_W'(push.push0);
   // keep space for the worst case of two results from the next beat
   assign room          = (count_ff <= RSP_ROOM_LIMIT);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.push0) + RSP_PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.push0) + RSP_CNT_W'(push.push1)
                  - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         entry_ff[wr_ptr_second] <= push.item1;
      end
   end

endmodule
`default_nettype wire

[design/tgad_checker.sv]
// Port checker for the TGA stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tgad_checker
   import tgad_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [7:0]  rsp_red,
   input wire logic [7:0]  rsp_run_length,
   input wire logic [15:0] rsp_image_width,
   input wire logic [15:0] rsp_image_height
);

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_run_length)
         && $stable(rsp_red) && $stable(rsp_image_width))
      else $error("stalled result beat changed");

   // pixel results always cover at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PIXEL |-> rsp_run_length != 8'd0)
      else $error("pixel result with zero run length");

   // header ok only reports a nonempty image
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_HEADER_OK |->
         rsp_image_width != 16'd0 && rsp_image_height != 16'd0
         && rsp_run_length == 8'd0)
      else $error("header ok with empty size");

endmodule

bind tga_stream_decoder tgad_checker u_tgad_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_red          (rsp_chan.red),
   .rsp_run_length   (rsp_chan.run_length),
   .rsp_image_width  (rsp_chan.image_width),
   .rsp_image_height (rsp_chan.image_height)
);
`default_nettype wire

[tb/sv/tb_tga_stream_decoder.sv]
// Self-checking testbench for the TGA stream decoder: byte streams in, decoded pixels checked.
`timescale 1ns / 1ps
module tb_tga_stream_decoder;
   import tgad_pkg::*;

   localparam int RANDOM_BYTES   = 950;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      logic [7:0] data;
      logic       sof;
      logic       eof;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tgad_req_if req_if();
   tgad_rsp_if rsp_if();

   tga_stream_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // file under construction, bytes waiting for the driver, decoded results still due
   stream_byte_type file_q[$];
   stream_byte_type pending_q[$];
   rsp_item_type decoded_q[$];
   int file_bytes = 0;

   // decoder state mirror
   phase_type  dec_phase   = PH_IDLE;
   logic [4:0] hdr_pos     = '0;
   logic       rle_mode    = 1'b0;
   logic [15:0] img_width  = '0;
   logic [15:0] img_height = '0;
   logic       four_bytes  = 1'b0;
   logic [31:0] pixels_left = '0;
   logic       run_packet  = 1'b0;
   logic [7:0] packet_left = '0;
   logic [1:0] byte_idx    = '0;
   logic [7:0] held_bytes [3] = '{default: '0};

   int mismatches = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int src_calm = 0;
   int stall_left = 0;
   int sink_calm = 0;
   stream_byte_type next_beat;
   rsp_item_type got;
   rsp_item_type want;

   // ---------------------------------------------------------------- decoder model

   function automatic rsp_item_type blank_result(status_type st);
      rsp_item_type r;
      r = '0;
      r.status = st;
      return r;
   endfunction

   task automatic clear_decoder();
      dec_phase   = PH_IDLE;
      hdr_pos     = '0;
      rle_mode    = 1'b0;
      img_width   = '0;
      img_height  = '0;
      four_bytes  = 1'b0;
      pixels_left = '0;
      run_packet  = 1'b0;
      packet_left = '0;
      byte_idx    = '0;
   endtask

   task automatic decode_byte(input logic [7:0] data, input logic sof, input logic eof);
      rsp_item_type r;
      logic [4:0] pos;
      logic [7:0] run;
      logic [7:0] left_after;
      logic bad;
      logic overflow;
      logic done;
      if (sof) begin
         clear_decoder();
         dec_phase = PH_HEADER;
      end
      case (dec_phase)
         PH_HEADER: begin
            pos = hdr_pos;
            if (pos < HDR_ID_LEN) begin
               if (pos == HDR_TYPE_POS) begin
                  bad = !(data == TYPE_RAW || data == TYPE_RLE);
                  rle_mode = (data == TYPE_RLE);
               end else begin
                  bad = (data != 8'd0);
               end
               if (bad) begin
                  decoded_q.push_back(blank_result(STATUS_BAD_TYPE));
                  dec_phase = PH_IDLE;
               end
            end else if (pos == HDR_WIDTH_LO) begin
               img_width[7:0] = data;
            end else if (pos == HDR_WIDTH_HI) begin
               img_width[15:8] = data;
            end else if (pos == HDR_HEIGHT_LO) begin
               img_height[7:0] = data;
            end else if (pos == HDR_HEIGHT_HI) begin
               img_height[15:8] = data;
            end else if (pos == HDR_BPP_POS) begin
               if (img_width == 16'd0 || img_height == 16'd0 ||
                   (data != BPP_24 && data != BPP_32)) begin
                  decoded_q.push_back(blank_result(STATUS_BAD_SIZE));
                  dec_phase = PH_IDLE;
               end else begin
                  four_bytes = (data == BPP_32);
               end
            end else begin
               // descriptor byte: header accepted
               pixels_left = 32'(img_width) * 32'(img_height);
               r = blank_result(STATUS_HEADER_OK);
               r.has_alpha    = four_bytes;
               r.image_width  = img_width;
               r.image_height = img_height;
               decoded_q.push_back(r);
               byte_idx    = '0;
               run_packet  = 1'b0;
               packet_left = '0;
               dec_phase   = rle_mode ? PH_PACKET : PH_PIXEL;
            end
            if (dec_phase == PH_HEADER) hdr_pos = pos + 5'd1;
         end
         PH_PACKET: begin
            if (data < RLE_REPEAT_FLAG) begin
               run_packet  = 1'b0;
               packet_left = data + 8'd1;
            end else begin
               run_packet  = 1'b1;
               packet_left = data - RLE_REPEAT_BIAS;
            end
            byte_idx  = '0;
            dec_phase = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (byte_idx < (four_bytes ? 2'd3 : 2'd2)) begin
               held_bytes[byte_idx] = data;
               byte_idx = byte_idx + 2'd1;
            end else begin
               r = blank_result(STATUS_PIXEL);
               r.blue      = held_bytes[0];
               r.green     = held_bytes[1];
               r.red       = four_bytes ? held_bytes[2] : data;
               r.alpha     = four_bytes ? data : 8'd0;
               r.has_alpha = four_bytes;
               byte_idx = '0;
               if (!rle_mode) begin
                  run = 8'd1;
                  left_after = 8'd0;
               end else if (run_packet) begin
                  // clip the run to what the image still needs
                  run = (32'(packet_left) < pixels_left) ? packet_left : pixels_left[7:0];
                  left_after = 8'd0;
               end else begin
                  run = 8'd1;
                  left_after = packet_left - 8'd1;
               end
               overflow = rle_mode && run_packet && (packet_left > run);
               pixels_left = pixels_left - 32'(run);
               packet_left = left_after;
               done = (pixels_left == 32'd0);
               r.run_length = run;
               r.image_done = done;
               decoded_q.push_back(r);
               if (done) begin
                  if (rle_mode && packet_left != 8'd0) overflow = 1'b1;
                  if (overflow) decoded_q.push_back(blank_result(STATUS_OVERFLOW));
                  dec_phase = PH_IDLE;
               end else if (rle_mode && packet_left == 8'd0) begin
                  dec_phase = PH_PACKET;
               end
            end
         end
         default: ;
      endcase
      if (eof && dec_phase != PH_IDLE) begin
         decoded_q.push_back(blank_result(STATUS_TRUNCATED));
         dec_phase = PH_IDLE;
      end
   endtask

   // ---------------------------------------------------------------- stream builders

   task automatic put(input logic [7:0] data, input logic sof = 1'b0, input logic eof = 1'b0);
      file_q.push_back('{data, sof, eof});
   endtask

   task automatic put_pixel(input bit wide);
      repeat (wide ? 4 : 3) put(8'($urandom_range(0, 255)));
   endtask

   task automatic put_header(input logic [7:0] code, input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] bpp, input logic [7:0] desc);
      for (int i = 0; i < 12; i++) put((i == 2) ? code : 8'd0, i == 0);
      put(w[7:0]);
      put(w[15:8]);
      put(h[7:0]);
      put(h[15:8]);
      put(bpp);
      put(desc);
   endtask

   // pixel data for a given pixel count; spill lets the last RLE packet run past the end
   task automatic put_body(input bit rle, input bit wide, input int pixels, input bit spill);
      int left;
      int cap;
      int cnt;
      int k;
      left = pixels;
      if (!rle) repeat (pixels) put_pixel(wide);
      while (rle && left > 0) begin
         cap = (left < 128) ? left : 128;
         if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, cap);
         else cnt = $urandom_range(1, (cap < 4) ? cap : 4);
         if (spill && left < 128 && $urandom_range(0, 2) == 0) cnt = $urandom_range(left + 1, 128);
         k = (cnt < left) ? cnt : left;
         if ($urandom_range(0, 1) == 1) begin
            put(8'(RLE_REPEAT_BIAS + cnt));
            put_pixel(wide);
         end else begin
            put(8'(cnt - 1));
            repeat (k) put_pixel(wide);
         end
         left -= k;
      end
   endtask

   // move the first keep bytes of the file to the driver queue
   task automatic commit(input int keep, input bit eof_last);
      stream_byte_type b;
      for (int i = 0; i < keep; i++) begin
         b = file_q[i];
         if (eof_last && i == keep - 1) b.eof = 1'b1;
         pending_q.push_back(b);
      end
      file_q.delete();
      file_bytes += keep;
   endtask

   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic string describe(rsp_item_type r);
      return $sformatf("status %0d rgba %02h %02h %02h %02h has_alpha %0b run %0d done %0b size %0dx%0d",
                       r.status, r.red, r.green, r.blue, r.alpha, r.has_alpha, r.run_length,
                       r.image_done, r.image_width, r.image_height);
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            decode_byte(req_if.data_byte, req_if.start_of_file, req_if.end_of_file);
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
               next_beat = pending_q.pop_front();
               req_if.data_byte     <= next_beat.data;
               req_if.start_of_file <= next_beat.sof;
               req_if.end_of_file   <= next_beat.eof;
               req_if.valid         <= 1'b1;
               send_gap = idle_length(src_calm);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result sink and checker

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left = idle_length(sink_calm);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '0;
         got.status       = status_type'(rsp_if.status);
         got.red          = rsp_if.red;
         got.green        = rsp_if.green;
         got.blue         = rsp_if.blue;
         got.alpha        = rsp_if.alpha;
         got.has_alpha    = rsp_if.has_alpha;
         got.run_length   = rsp_if.run_length;
         got.image_done   = rsp_if.image_done;
         got.image_width  = rsp_if.image_width;
         got.image_height = rsp_if.image_height;
         if (decoded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", describe(got));
         end else begin
            want = decoded_q.pop_front();
            if (got.status !== want.status || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.has_alpha !== want.has_alpha ||
                got.run_length !== want.run_length || got.image_done !== want.image_done ||
                got.image_width !== want.image_width ||
                got.image_height !== want.image_height) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch\n  expected %s\n  actual   %s", describe(want), describe(got));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL tga_stream_decoder");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus and run control

   initial begin
      int sel;
      int w;
      int h;
      int pos;
      int v;
      bit rle;
      bit wide;
      logic [7:0] bpp;

      req_if.valid         = 1'b0;
      req_if.data_byte     = 8'd0;
      req_if.start_of_file = 1'b0;
      req_if.end_of_file   = 1'b0;
      rsp_if.ready         = 1'b0;

      // start byte that is also the last one: truncated inside the header
      put(8'h00, 1'b1, 1'b1);
      // bytes outside any file are dropped
      put(8'hFF);
      put(8'h00, 1'b0, 1'b1);
      // wrong first byte, then wrong image type
      put(8'h80, 1'b1);
      put(8'h00, 1'b1);
      put(8'h00);
      put(8'd3);
      commit(file_q.size(), 1'b0);
      // raw 24 bpp single pixel at the byte extremes, last byte carries end of file
      put_header(TYPE_RAW, 16'd1, 16'd1, BPP_24, 8'hFF);
      put(8'h00);
      put(8'hFF);
      put(8'h5A);
      commit(file_q.size(), 1'b1);
      // longest repeat clipped to a 2-pixel image
      put_header(TYPE_RLE, 16'd2, 16'd1, BPP_32, 8'h00);
      put(8'hFF);
      put(8'hFF); put(8'h00); put(8'hFF); put(8'h00);
      commit(file_q.size(), 1'b0);
      // longest raw packet runs past a 3-pixel image
      put_header(TYPE_RLE, 16'd3, 16'd1, BPP_24, 8'h00);
      put(8'h7F);
      repeat (3) put_pixel(1'b0);
      commit(file_q.size(), 1'b0);
      // shortest repeat, then shortest raw packet
      put_header(TYPE_RLE, 16'd1, 16'd2, BPP_32, 8'h00);
      put(RLE_REPEAT_FLAG);
      put_pixel(1'b1);
      put(8'h00);
      put_pixel(1'b1);
      commit(file_q.size(), 1'b1);
      // bad sizes: zero width, zero height, unsupported depth
      put_header(TYPE_RAW, 16'd0, 16'd5, BPP_24, 8'h00);
      put_header(TYPE_RLE, 16'd7, 16'd0, BPP_32, 8'h00);
      put_header(TYPE_RAW, 16'd3, 16'd3, 8'd33, 8'h00);
      commit(file_q.size(), 1'b0);
      // largest image, cut off after the second packet byte
      put_header(TYPE_RLE, 16'hFFFF, 16'hFFFF, BPP_32, 8'h20);
      put(8'hFF);
      put_pixel(1'b1);
      put(8'h00);
      commit(file_q.size(), 1'b1);
      // header ok and truncation on the same byte
      put_header(TYPE_RAW, 16'd2, 16'd2, BPP_24, 8'h00);
      commit(file_q.size(), 1'b1);
      // drop the file mid-pixel; the next start aborts it
      put_header(TYPE_RAW, 16'd4, 16'd4, BPP_32, 8'h00);
      put_pixel(1'b1);
      commit(file_q.size() - 2, 1'b0);

      while (file_bytes < RANDOM_BYTES) begin
         sel  = $urandom_range(0, 99);
         rle  = $urandom_range(0, 1);
         wide = $urandom_range(0, 1);
         bpp  = wide ? BPP_32 : BPP_24;
         w    = $urandom_range(1, 4);
         h    = $urandom_range(1, 4);
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 1) w = $urandom_range(5, 40);
            else h = $urandom_range(5, 40);
         end
         if (sel < 6) begin
            // noise between files
            repeat ($urandom_range(1, 4))
               put(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                   $urandom_range(0, 3) == 0);
            commit(file_q.size(), 1'b0);
         end else if (sel < 62) begin
            put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), bpp,
                       8'($urandom_range(0, 255)));
            put_body(rle, wide, w * h, $urandom_range(0, 3) == 0);
            commit(file_q.size(), $urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 3))
                  put(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1));
               commit(file_q.size(), 1'b0);
            end
         end else if (sel < 74) begin
            // large image: send only its start
            w = $urandom_range(1, 65535);
            h = $urandom_range(1, 65535);
            put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), bpp,
                       8'($urandom_range(0, 255)));
            put_body(rle, wide, $urandom_range(0, 6), 1'b0);
            commit(file_q.size(), $urandom_range(0, 2) != 0);
         end else if (sel < 86) begin
            put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), bpp,
                       8'($urandom_range(0, 255)));
            put_body(rle, wide, w * h, $urandom_range(0, 3) == 0);
            commit($urandom_range(1, file_q.size() - 1), $urandom_range(0, 3) != 0);
         end else if (sel < 94) begin
            // corrupt one byte of the type header
            put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), bpp, 8'h00);
            put_pixel(wide);
            pos = $urandom_range(0, 11);
            if (pos == 2) begin
               do v = $urandom_range(0, 255); while (v == TYPE_RAW || v == TYPE_RLE);
            end else begin
               v = $urandom_range(1, 255);
            end
            file_q[pos].data = 8'(v);
            commit(file_q.size(), $urandom_range(0, 1));
         end else begin
            case ($urandom_range(0, 2))
               0: w = 0;
               1: h = 0;
               default: begin
                  do v = $urandom_range(0, 255); while (v == BPP_24 || v == BPP_32);
                  bpp = 8'(v);
               end
            endcase
            put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), bpp,
                       8'($urandom_range(0, 255)));
            put_pixel(wide);
            commit(file_q.size(), $urandom_range(0, 1));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || req_if.valid || decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("PASS tga_stream_decoder");
      end else begin
         $display("FAIL tga_stream_decoder");
      end
      $finish;
   end

endmodule
